// ===== rtl/bpc_pkg.sv =====
// Shared types, constants and a helper function of the bitmask pixel collision block.
// Used by every module under rtl; depends on nothing else.
package bpc_pkg;

  localparam int ROW_W = 64;
  localparam int DIM_W = 7;
  localparam int POS_W = 16;
  localparam int Y_W = 7;
  localparam int COL_W = 6;

  localparam int MAX_W_DEF = 64;
  localparam int MAX_H_DEF = 64;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd8;

  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] REG_A_WIDTH = 2'd0;
  localparam logic [1:0] REG_A_HEIGHT = 2'd1;
  localparam logic [1:0] REG_B_WIDTH = 2'd2;
  localparam logic [1:0] REG_B_HEIGHT = 2'd3;

  typedef struct packed {
    logic [ROW_W-1:0] mask_a;
    logic [ROW_W-1:0] mask_b;
    logic             sh_left;
    logic             sh_zero;
    logic [COL_W-1:0] sh_amt;
    logic             rev;
  } row_ctl_t;

  function automatic logic [ROW_W-1:0] clip_mask(input logic [DIM_W-1:0] w);
    logic [DIM_W-1:0] sh;
    sh = 7'd64 - w;
    return {ROW_W{1'b1}} << sh;
  endfunction

endpackage

// ===== rtl/bpc_row_mem.sv =====
// One mask store: a row array with one write port and one registered read port.
// Uses bpc_pkg for the row width.
module bpc_row_mem #(
  parameter int DEPTH = bpc_pkg::MAX_H_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [bpc_pkg::ROW_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [bpc_pkg::ROW_W-1:0] rdata
);

  logic [bpc_pkg::ROW_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bpc_row_unit.sv =====
// Shared row unit: clips both rows, shifts row B by the x offset and ANDs them.
// Uses bpc_pkg for the row control struct.
module bpc_row_unit (
  input  logic [bpc_pkg::ROW_W-1:0] row_a,
  input  logic [bpc_pkg::ROW_W-1:0] row_b,
  input  bpc_pkg::row_ctl_t         ctl,
  output logic                      any,
  output logic [bpc_pkg::ROW_W-1:0] both
);

  logic [bpc_pkg::ROW_W-1:0] wa;
  logic [bpc_pkg::ROW_W-1:0] wb;
  logic [bpc_pkg::ROW_W-1:0] wb_sh;
  logic [bpc_pkg::ROW_W-1:0] raw;

  always_comb begin
    wa = row_a & ctl.mask_a;
    wb = row_b & ctl.mask_b;
    if (ctl.sh_zero) begin
      wb_sh = '0;
    end else if (ctl.sh_left) begin
      wb_sh = wb << ctl.sh_amt;
    end else begin
      wb_sh = wb >> ctl.sh_amt;
    end
    raw = wa & wb_sh;
    any = |raw;
    // For a right-to-left search the word is mirrored so both searches look from the top bit.
    for (int i = 0; i < bpc_pkg::ROW_W; i++) begin
      both[i] = ctl.rev ? raw[bpc_pkg::ROW_W-1-i] : raw[i];
    end
  end

endmodule

// ===== rtl/bpc_ctrl.sv =====
// Query sequencer: bounding box test, row band walk over the shared row unit,
// two-step first-pixel search and the result register. Uses bpc_pkg.
module bpc_ctrl #(
  parameter int MAX_W = bpc_pkg::MAX_W_DEF,
  parameter int MAX_H = bpc_pkg::MAX_H_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [bpc_pkg::POS_W-1:0]       q_ax,
  input  logic [bpc_pkg::POS_W-1:0]       q_ay,
  input  logic [bpc_pkg::POS_W-1:0]       q_bx,
  input  logic [bpc_pkg::POS_W-1:0]       q_by,
  input  logic [1:0]                      q_order,
  input  logic [bpc_pkg::DIM_W-1:0]       a_width,
  input  logic [bpc_pkg::DIM_W-1:0]       a_height,
  input  logic [bpc_pkg::DIM_W-1:0]       b_width,
  input  logic [bpc_pkg::DIM_W-1:0]       b_height,
  output logic                            idle,
  output logic [bpc_pkg::Y_W-1:0]         rd_addr_a,
  output logic [bpc_pkg::Y_W-1:0]         rd_addr_b,
  output bpc_pkg::row_ctl_t               row_ctl,
  input  logic                            row_any,
  input  logic [bpc_pkg::ROW_W-1:0]       row_both,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic                            out_hit,
  output logic [bpc_pkg::POS_W-1:0]       out_x,
  output logic [bpc_pkg::POS_W-1:0]       out_y
);

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_RANGE, S_SCAN, S_FIND1, S_FIND2, S_RESULT
  } state_t;

  localparam logic [8:0] MAX_W9 = 9'(MAX_W);
  localparam logic [8:0] MAX_H9 = 9'(MAX_H);

  state_t state_r;
  logic [bpc_pkg::POS_W-1:0] ax_r, ay_r, bx_r, by_r;
  logic [1:0] order_r;
  logic [bpc_pkg::POS_W:0] dx_r, dy_r;
  logic reject_r;
  bpc_pkg::row_ctl_t ctl_r;
  logic [bpc_pkg::Y_W-1:0] cur_y_r, last_y_r, p1_y_r, hit_row_r;
  logic issue_r, p1_valid_r;
  logic [bpc_pkg::ROW_W-1:0] v_r;
  logic [2:0] grp_r;
  logic [7:0] byte_r;
  logic res_hit_r;
  logic [bpc_pkg::POS_W-1:0] res_x_r, res_y_r;
  logic out_valid_r, out_hit_r;
  logic [bpc_pkg::POS_W-1:0] out_x_r, out_y_r;

  logic bad_dims, separated;
  logic [bpc_pkg::POS_W+1:0] ax_e, bx_e, ay_e, by_e, a_right, b_right, a_bot, b_bot;
  logic [bpc_pkg::POS_W:0] dx_nxt, dy_nxt, dx_mag;
  logic [bpc_pkg::POS_W+1:0] y1_sum;
  logic [bpc_pkg::Y_W-1:0] y0_nxt, y1_nxt, y1_last;
  logic [2:0] grp_nxt, bit_nxt;
  logic [bpc_pkg::COL_W-1:0] clz, col;

  always_comb begin
    bad_dims = (a_width == '0) || (a_height == '0) || (b_width == '0) || (b_height == '0)
               || ({2'd0, a_width} > MAX_W9) || ({2'd0, b_width} > MAX_W9)
               || ({2'd0, a_height} > MAX_H9) || ({2'd0, b_height} > MAX_H9);
    ax_e = {{2{ax_r[15]}}, ax_r};
    bx_e = {{2{bx_r[15]}}, bx_r};
    ay_e = {{2{ay_r[15]}}, ay_r};
    by_e = {{2{by_r[15]}}, by_r};
    a_right = ax_e + {11'd0, a_width};
    b_right = bx_e + {11'd0, b_width};
    a_bot = ay_e + {11'd0, a_height};
    b_bot = by_e + {11'd0, b_height};
    separated = ($signed(a_right) <= $signed(bx_e)) || ($signed(b_right) <= $signed(ax_e))
                || ($signed(a_bot) <= $signed(by_e)) || ($signed(b_bot) <= $signed(ay_e));
    dx_nxt = {bx_r[15], bx_r} - {ax_r[15], ax_r};
    dy_nxt = {by_r[15], by_r} - {ay_r[15], ay_r};

    y0_nxt = dy_r[16] ? '0 : dy_r[6:0];
    y1_sum = {dy_r[16], dy_r} + {11'd0, b_height};
    y1_nxt = ($signed(y1_sum) > $signed({11'd0, a_height})) ? a_height : y1_sum[6:0];
    y1_last = y1_nxt - 7'd1;
    dx_mag = dx_r[16] ? (~dx_r + 17'd1) : dx_r;

    grp_nxt = '0;
    for (int g = 7; g >= 0; g--) begin
      if (|v_r[63-8*g -: 8]) begin
        grp_nxt = 3'(g);
      end
    end
    bit_nxt = '0;
    for (int b = 7; b >= 0; b--) begin
      if (byte_r[7-b]) begin
        bit_nxt = 3'(b);
      end
    end
    clz = {grp_r, bit_nxt};
    col = order_r[0] ? ~clz : clz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      issue_r <= 1'b0;
      p1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_RESULT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            ax_r <= q_ax;
            ay_r <= q_ay;
            bx_r <= q_bx;
            by_r <= q_by;
            order_r <= q_order;
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          reject_r <= bad_dims || separated;
          dx_r <= dx_nxt;
          dy_r <= dy_nxt;
          state_r <= S_RANGE;
        end
        S_RANGE: begin
          ctl_r.mask_a <= bpc_pkg::clip_mask(a_width);
          ctl_r.mask_b <= bpc_pkg::clip_mask(b_width);
          ctl_r.sh_left <= dx_r[16];
          ctl_r.sh_zero <= |dx_mag[16:6];
          ctl_r.sh_amt <= dx_mag[5:0];
          ctl_r.rev <= order_r[0];
          cur_y_r <= order_r[1] ? y1_last : y0_nxt;
          last_y_r <= order_r[1] ? y0_nxt : y1_last;
          issue_r <= 1'b1;
          p1_valid_r <= 1'b0;
          res_hit_r <= 1'b0;
          res_x_r <= '0;
          res_y_r <= '0;
          state_r <= reject_r ? S_RESULT : S_SCAN;
        end
        S_SCAN: begin
          p1_valid_r <= issue_r;
          p1_y_r <= cur_y_r;
          if (issue_r) begin
            if (cur_y_r == last_y_r) begin
              issue_r <= 1'b0;
            end else if (order_r[1]) begin
              cur_y_r <= cur_y_r - 7'd1;
            end else begin
              cur_y_r <= cur_y_r + 7'd1;
            end
          end
          if (p1_valid_r && row_any) begin
            v_r <= row_both;
            hit_row_r <= p1_y_r;
            state_r <= S_FIND1;
          end else if (p1_valid_r && !issue_r) begin
            state_r <= S_RESULT;
          end
        end
        S_FIND1: begin
          grp_r <= grp_nxt;
          byte_r <= v_r[63-8*grp_nxt -: 8];
          state_r <= S_FIND2;
        end
        S_FIND2: begin
          res_hit_r <= 1'b1;
          res_x_r <= ax_r + {10'd0, col};
          res_y_r <= ay_r + {9'd0, hit_row_r};
          state_r <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_hit_r <= res_hit_r;
            out_x_r <= res_x_r;
            out_y_r <= res_y_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign idle = (state_r == S_IDLE);
  assign rd_addr_a = cur_y_r;
  assign rd_addr_b = cur_y_r - dy_r[6:0];
  assign row_ctl = ctl_r;
  assign out_valid = out_valid_r;
  assign out_hit = out_hit_r;
  assign out_x = out_x_r;
  assign out_y = out_y_r;

endmodule

// ===== rtl/bitmask_pixel_collision.sv =====
// Top level of the bitmask pixel collision block: ports, configuration registers,
// mask stores and the query sequencer. Uses bpc_pkg, bpc_row_mem, bpc_row_unit, bpc_ctrl.
//
// Input items arrive on the in_ stream. in_tuser selects the kind of item: a load
// of one row of mask A, a load of one row of mask B, or a collision query. Loads
// give no result. A query gives exactly one result item on the out_ stream:
// out_tuser is the hit flag, out_tdata the contact coordinates. A query walks the
// rows of the overlapping band, at most 127 (64 with default sizes). The row loop
// reads one row pair per cycle from the two mask memories and feeds it through one
// shift and AND unit. A rejected query skips the row walk.
// in_tready is low while a query runs. A result waits in the output register while
// the receiver stalls; loads are still taken then, and a new query runs but holds
// its result until the register is free.
// The four size registers sit on the cfg_ port at byte addresses 0, 4, 8 and 12
// and must be written only while the block is idle; the block does not enforce
// this. Reset sets all sizes to 8 and clears the control state; mask rows hold no
// value until loaded.
module bitmask_pixel_collision #(
  parameter int MAX_W = bpc_pkg::MAX_W_DEF,
  parameter int MAX_H = bpc_pkg::MAX_H_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // row_index[5:0], row_bits[69:6], pos_ax[85:70], pos_ay[101:86],
  // pos_bx[117:102], pos_by[133:118], scan_order[135:134]
  input  logic [135:0] in_tdata,
  // opcode[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // hit_x[15:0], hit_y[31:16]
  output logic [31:0]  out_tdata,
  // hit[0]
  output logic         out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int AW = (MAX_H > 1) ? $clog2(MAX_H) : 1;

  logic [bpc_pkg::DIM_W-1:0] a_width_r, a_height_r, b_width_r, b_height_r;
  logic cfg_wr, in_acc, load_ok, idle;
  logic [bpc_pkg::Y_W-1:0] rd_addr_a, rd_addr_b;
  logic [bpc_pkg::ROW_W-1:0] rdata_a, rdata_b, both;
  logic row_any, out_hit;
  logic [bpc_pkg::POS_W-1:0] out_x, out_y;
  bpc_pkg::row_ctl_t row_ctl;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_width_r <= bpc_pkg::DIM_RESET;
      a_height_r <= bpc_pkg::DIM_RESET;
      b_width_r <= bpc_pkg::DIM_RESET;
      b_height_r <= bpc_pkg::DIM_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        bpc_pkg::REG_A_WIDTH: a_width_r <= cfg_pwdata[6:0];
        bpc_pkg::REG_A_HEIGHT: a_height_r <= cfg_pwdata[6:0];
        bpc_pkg::REG_B_WIDTH: b_width_r <= cfg_pwdata[6:0];
        bpc_pkg::REG_B_HEIGHT: b_height_r <= cfg_pwdata[6:0];
        default: a_width_r <= a_width_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      bpc_pkg::REG_A_WIDTH: cfg_prdata = {25'd0, a_width_r};
      bpc_pkg::REG_A_HEIGHT: cfg_prdata = {25'd0, a_height_r};
      bpc_pkg::REG_B_WIDTH: cfg_prdata = {25'd0, b_width_r};
      bpc_pkg::REG_B_HEIGHT: cfg_prdata = {25'd0, b_height_r};
      default: cfg_prdata = '0;
    endcase
  end

  assign in_tready = idle;
  assign in_acc = in_tvalid && idle;
  assign load_ok = in_acc && ({26'd0, in_tdata[5:0]} < 32'(MAX_H));

  bpc_row_mem #(.DEPTH(MAX_H)) u_mem_a (
    .clk   (clk),
    .we    (load_ok && (in_tuser == bpc_pkg::OP_LOAD_A)),
    .waddr (AW'(in_tdata[5:0])),
    .wdata (in_tdata[69:6]),
    .raddr (AW'(rd_addr_a)),
    .rdata (rdata_a)
  );

  bpc_row_mem #(.DEPTH(MAX_H)) u_mem_b (
    .clk   (clk),
    .we    (load_ok && (in_tuser == bpc_pkg::OP_LOAD_B)),
    .waddr (AW'(in_tdata[5:0])),
    .wdata (in_tdata[69:6]),
    .raddr (AW'(rd_addr_b)),
    .rdata (rdata_b)
  );

  bpc_row_unit u_row (
    .row_a (rdata_a),
    .row_b (rdata_b),
    .ctl   (row_ctl),
    .any   (row_any),
    .both  (both)
  );

  bpc_ctrl #(.MAX_W(MAX_W), .MAX_H(MAX_H)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc && (in_tuser == bpc_pkg::OP_QUERY)),
    .q_ax      (in_tdata[85:70]),
    .q_ay      (in_tdata[101:86]),
    .q_bx      (in_tdata[117:102]),
    .q_by      (in_tdata[133:118]),
    .q_order   (in_tdata[135:134]),
    .a_width   (a_width_r),
    .a_height  (a_height_r),
    .b_width   (b_width_r),
    .b_height  (b_height_r),
    .idle      (idle),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .row_ctl   (row_ctl),
    .row_any   (row_any),
    .row_both  (both),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_hit   (out_hit),
    .out_x     (out_x),
    .out_y     (out_y)
  );

  assign out_tuser = out_hit;
  assign out_tdata = {out_y, out_x};

endmodule

// ===== sim/bitmask_pixel_collision_test.sv =====
// Self-checking testbench for bitmask_pixel_collision: loads mask rows, sets mask
// sizes over the cfg_ port and checks every query result against its own predictor.
// Depends only on bpc_pkg and the bitmask_pixel_collision RTL.
`timescale 1ns / 1ps

module bitmask_pixel_collision_test;

  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE_CYCLES = 200;
  localparam int ITEMS_PER_SETTING = 125;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } collision_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic [1:0]   in_tuser = bpc_pkg::OP_LOAD_A;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;
  logic         out_tuser;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [3:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  logic [63:0]  a_rows [64];
  logic [63:0]  b_rows [64];
  logic [6:0]   a_w = bpc_pkg::DIM_RESET, a_h = bpc_pkg::DIM_RESET;
  logic [6:0]   b_w = bpc_pkg::DIM_RESET, b_h = bpc_pkg::DIM_RESET;

  collision_t   collision_q[$];
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  int           failures = 0;
  int           cycles = 0;
  int           n_queries = 0, n_hits = 0, n_loads = 0, n_settings = 0;

  bitmask_pixel_collision uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic logic [63:0] clip_row(logic [63:0] row, int w);
    if (w < 64) row &= ~64'd0 << (64 - w);
    return row;
  endfunction

  function automatic int contact_column(logic [63:0] both, bit left);
    int col;
    col = 0;
    for (int i = 0; i < 64; i++) begin
      if (left && both[63 - i]) return i;
      if (!left && both[i]) return 63 - i;
    end
    return col;
  endfunction

  function automatic collision_t predict_collision(logic signed [15:0] pax, pay, pbx, pby,
                                                   logic [1:0] order);
    int ax, ay, bx, by, aw, ah, bw, bh, dx, dy, y0, y1, y, yb;
    logic [63:0] wa, wb, both;
    collision_t r;
    ax = pax; ay = pay; bx = pbx; by = pby;
    aw = a_w; ah = a_h; bw = b_w; bh = b_h;
    r = '0;
    if (aw == 0 || ah == 0 || bw == 0 || bh == 0) return r;
    if (aw > 64 || bw > 64 || ah > 64 || bh > 64) return r;
    if (ax + aw <= bx || bx + bw <= ax) return r;
    if (ay + ah <= by || by + bh <= ay) return r;
    dx = bx - ax;
    dy = by - ay;
    y0 = (dy > 0) ? dy : 0;
    y1 = (dy + bh > ah) ? ah : dy + bh;
    for (int k = y0; k < y1; k++) begin
      y = order[1] ? (y1 - 1 - (k - y0)) : k;
      yb = y - dy;
      if (y < 0 || y >= 64 || yb < 0 || yb >= 64) continue;
      wa = clip_row(a_rows[y], aw);
      wb = clip_row(b_rows[yb], bw);
      if (dx >= 0) wb = (dx >= 64) ? 64'd0 : wb >> dx;
      else wb = (-dx >= 64) ? 64'd0 : wb << -dx;
      both = wa & wb;
      if (both != 0) begin
        r.hit = 1'b1;
        r.x = 16'(ax + contact_column(both, !order[0]));
        r.y = 16'(ay + y);
        return r;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    collision_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.hit = out_tuser;
      got.x = out_tdata[15:0];
      got.y = out_tdata[31:16];
      if (collision_q.size() == 0) begin
        $error("result item with no query pending: hit %0d x %0d y %0d",
               got.hit, got.x, got.y);
        failures++;
      end else begin
        want = collision_q.pop_front();
        if (got.hit !== want.hit) begin
          $error("hit mismatch: expected %0d, got %0d", want.hit, got.hit);
          failures++;
        end
        if (got.x !== want.x) begin
          $error("hit_x mismatch: expected %0d, got %0d", want.x, got.x);
          failures++;
        end
        if (got.y !== want.y) begin
          $error("hit_y mismatch: expected %0d, got %0d", want.y, got.y);
          failures++;
        end
        if (got.hit) n_hits++;
      end
    end
  end

  task automatic send_item(logic [1:0] op, logic [5:0] idx, logic [63:0] bits,
                           logic [15:0] ax, ay, bx, by, logic [1:0] order);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {order, by, bx, ay, ax, bits, idx};
    do @(posedge clk); while (!in_tready);
    case (op)
      bpc_pkg::OP_LOAD_A: begin
        a_rows[idx] = bits;
        n_loads++;
      end
      bpc_pkg::OP_LOAD_B: begin
        b_rows[idx] = bits;
        n_loads++;
      end
      bpc_pkg::OP_QUERY: begin
        collision_q.push_back(predict_collision(ax, ay, bx, by, order));
        n_queries++;
      end
      default: ;
    endcase
  endtask

  task automatic load_row(logic [1:0] op, logic [5:0] idx, logic [63:0] bits);
    send_item(op, idx, bits, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              2'($urandom));
  endtask

  task automatic query(logic [15:0] ax, ay, bx, by, logic [1:0] order);
    send_item(bpc_pkg::OP_QUERY, 6'($urandom), {$urandom, $urandom}, ax, ay, bx, by, order);
  endtask

  function automatic logic [63:0] random_row();
    int mode;
    mode = $urandom_range(0, 99);
    if (mode < 40) return {$urandom, $urandom};
    if (mode < 75) return {$urandom, $urandom} & {$urandom, $urandom} &
                          {$urandom, $urandom} & {$urandom, $urandom};
    if (mode < 90) return 64'd1 << $urandom_range(0, 63);
    return 64'd0;
  endfunction

  task automatic near_query();
    logic [15:0] ax, ay;
    ax = 16'($urandom);
    ay = 16'($urandom);
    query(ax, ay, ax + 16'($urandom_range(0, 140)) - 16'd70,
          ay + 16'($urandom_range(0, 140)) - 16'd70, 2'($urandom));
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (collision_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] reg_idx, logic [6:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_idx, 2'b00};
    cfg_pwdata <= {25'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (reg_idx)
      bpc_pkg::REG_A_WIDTH: a_w = value;
      bpc_pkg::REG_A_HEIGHT: a_h = value;
      bpc_pkg::REG_B_WIDTH: b_w = value;
      bpc_pkg::REG_B_HEIGHT: b_h = value;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_sizes(logic [6:0] aw, ah, bw, bh);
    wait_idle();
    cfg_write(bpc_pkg::REG_A_WIDTH, aw);
    cfg_write(bpc_pkg::REG_A_HEIGHT, ah);
    cfg_write(bpc_pkg::REG_B_WIDTH, bw);
    cfg_write(bpc_pkg::REG_B_HEIGHT, bh);
    n_settings++;
  endtask

  function automatic logic [6:0] random_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 7'($urandom_range(1, 64));
    if (r < 80) return 7'($urandom_range(1, 6));
    if (r < 90) return 7'd64;
    case ($urandom_range(0, 3))
      0: return 7'd0;
      1: return 7'd65;
      2: return 7'd127;
      default: return 7'($urandom);
    endcase
  endfunction

  // Every row of both masks is written before the first query.
  task automatic test_fill_masks();
    for (int i = 0; i < 64; i++) begin
      load_row(bpc_pkg::OP_LOAD_A, 6'(i), random_row());
      load_row(bpc_pkg::OP_LOAD_B, 6'(i), random_row());
    end
  endtask

  task automatic test_directed_cases();
    load_row(bpc_pkg::OP_LOAD_A, 6'd0, '1);
    load_row(bpc_pkg::OP_LOAD_B, 6'd0, '1);
    load_row(bpc_pkg::OP_LOAD_A, 6'd7, '0);
    for (int o = 0; o < 4; o++) query(16'd0, 16'd0, 16'd0, 16'd0, 2'(o));
    query(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 2'd3);
    query(16'h8000, 16'h8000, 16'h8000, 16'h8000, 2'd0);
    query(16'd100, 16'd100, 16'd108, 16'd100, 2'd0);
    query(16'd100, 16'd100, 16'd100, 16'd108, 2'd0);
    query(16'd100, 16'd100, 16'd107, 16'd100, 2'd0);
    query(16'd100, 16'd100, 16'd93, 16'd100, 2'd1);
    query(16'd0, 16'd0, 16'd0, 16'd7, 2'd2);
    query(16'hfffc, 16'hfffc, 16'd3, 16'd3, 2'd3);
    send_item(OP_IGNORED, '1, '1, '1, '1, '1, '1, '1);
    load_row(bpc_pkg::OP_LOAD_A, 6'd63, 64'd1);
    load_row(bpc_pkg::OP_LOAD_B, 6'd63, 64'd1);
  endtask

  task automatic test_size_extremes();
    apply_sizes(7'd64, 7'd64, 7'd64, 7'd64);
    for (int o = 0; o < 4; o++) query(16'd0, 16'd0, 16'd0, 16'd0, 2'(o));
    apply_sizes(7'd1, 7'd1, 7'd1, 7'd1);
    query(16'd5, 16'd5, 16'd5, 16'd5, 2'd0);
    apply_sizes(7'd0, 7'd8, 7'd8, 7'd8);
    query(16'd0, 16'd0, 16'd0, 16'd0, 2'd0);
    apply_sizes(7'd8, 7'd0, 7'd8, 7'd8);
    query(16'd0, 16'd0, 16'd0, 16'd0, 2'd1);
    apply_sizes(7'd8, 7'd8, 7'd0, 7'd8);
    query(16'd0, 16'd0, 16'd0, 16'd0, 2'd2);
    apply_sizes(7'd8, 7'd8, 7'd8, 7'd0);
    query(16'd0, 16'd0, 16'd0, 16'd0, 2'd3);
    apply_sizes(7'd65, 7'd8, 7'd8, 7'd8);
    query(16'd0, 16'd0, 16'd0, 16'd0, 2'd0);
    apply_sizes(7'd8, 7'd8, 7'd127, 7'd8);
    query(16'd0, 16'd0, 16'd0, 16'd0, 2'd0);
    apply_sizes(7'd8, 7'd64, 7'd8, 7'd127);
    query(16'd0, 16'd0, 16'd0, 16'd0, 2'd0);
    apply_sizes(7'd64, 7'd1, 7'd1, 7'd64);
    query(16'd0, 16'd0, 16'd63, 16'hffc1, 2'd1);
    near_query();
  endtask

  task automatic test_random_traffic();
    int r, sent;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 73; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 73; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      for (int s = 0; s < 4; s++) begin
        apply_sizes(random_dim(), random_dim(), random_dim(), random_dim());
        sent = 0;
        while (sent < ITEMS_PER_SETTING) begin
          r = $urandom_range(0, 99);
          if (r < 3) begin
            send_item(OP_IGNORED, 6'($urandom), {$urandom, $urandom}, 16'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom), 2'($urandom));
          end else begin
            if (r < 18) load_row(bpc_pkg::OP_LOAD_A, 6'($urandom), random_row());
            else if (r < 33) load_row(bpc_pkg::OP_LOAD_B, 6'($urandom), random_row());
            else if (r < 45) query(16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom), 2'($urandom));
            else near_query();
            sent++;
          end
        end
      end
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_masks();
    test_directed_cases();
    test_size_extremes();
    test_random_traffic();
    wait_idle();
    $display("Covered %0d mask size settings with all idle and stall phases.", n_settings);
    $display("Sent %0d row loads and %0d queries; %0d queries found contact.",
             n_loads, n_queries, n_hits);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bpc_pkg.sv
rtl/bpc_row_mem.sv
rtl/bpc_row_unit.sv
rtl/bpc_ctrl.sv
rtl/bitmask_pixel_collision.sv
sim/bitmask_pixel_collision_test.sv
